[hdl/prs_pkg.sv]
// Shared types and constants for the periodic request scheduler.
// Holds the field widths, the table entry layout and the microcode control word.
// No dependencies; used by prs_useq and periodic_request_scheduler_core.
package prs_pkg;

  // Default table depth.
  localparam int PRS_MAX_ENTRIES = 16;

  // Field widths of the stream words and the configuration register.
  localparam int SLOT_FIELD_W  = 4;
  localparam int ID_W          = 11;
  localparam int PID_W         = 16;
  localparam int MODE_W        = 8;
  localparam int IVAL_W        = 16;
  localparam int TIME_W        = 16;
  localparam int ENTRY_COUNT_W = 5;

  // Packed stream widths, rounded up to whole bytes.
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 40;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

  // One table entry as loaded by a load word.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PID_W-1:0]  pid;
    logic [ID_W-1:0]   can_id;
    logic [IVAL_W-1:0] interval;
  } entry_t;

  // Microcode step address.
  typedef logic [3:0] step_t;

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SETUP,
    OP_REDUCE,
    OP_START,
    OP_ADVANCE,
    OP_GRANT,
    OP_MISS,
    OP_LOAD
  } op_t;

  // Branch condition tested by a control word.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_IS_LOAD,
    COND_COUNT_ZERO,
    COND_PTR_GE,
    COND_DUE,
    COND_LAST,
    COND_OUT_BUSY
  } cond_t;

  // One microcode word: branch to t_true when the condition holds, else t_false.
  typedef struct packed {
    logic  ready;
    op_t   op;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } ctrl_word_t;

  // Status flags returned from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic is_load;
    logic count_zero;
    logic ptr_ge;
    logic due;
    logic last;
    logic out_busy;
  } cond_flags_t;

endpackage

[hdl/periodic_request_scheduler_core.sv]
// Periodic request scheduler: table of periodic requests with a round-robin due scan.
// Top level: datapath, request tables and configuration port; depends on prs_pkg
// and prs_useq.
//
// Usage: the input stream carries load words (s_tuser = 0), which write one table
// slot and clear its issue stamp, and request words (s_tuser = 1), which carry the
// current millisecond time. Each request word yields exactly one output word: the
// next due slot after the last one granted, or m_tuser = 0 with zero data when no
// active slot is due. Load words yield no output.
// The APB port holds entry_count at address 0; write it only while the block is idle.
// Sequencing: a microcoded sequencer handles one word at a time. A load word passes
// the latch, decode and load steps. A request word passes the latch, decode and
// zero-test steps, a reduce step repeated while the round-robin pointer must be
// folded below the active count (only after entry_count was lowered), the start
// step, an evaluate step per slot examined with an advance step after each slot not
// granted, and ends in the grant or miss step; with entry_count 0 it goes from the
// zero test to the miss step. Evaluate and advance are split because the tables are
// memories with a registered read port. An output register separates the two sides:
// a new word is accepted while a result waits; if the receiver stalls, the
// sequencer holds in its result step until the output register is free.
// Reset clears the pointer, the issue stamps (via per-slot valid bits), the output
// valid flag and sets entry_count to 1; request fields are undefined until loaded.
module periodic_request_scheduler_core #(
  parameter int MAX_ENTRIES = prs_pkg::PRS_MAX_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata fields from bit 0: slot[3:0], entry_id[14:4], entry_pid[30:15],
  // entry_mode[38:31], entry_interval[54:39], now_ms[70:55], zero pad[71].
  input  logic [prs_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser fields from bit 0: action.
  input  logic                            s_tuser,
  // Output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata fields from bit 0: grant_slot[3:0], grant_id[14:4], grant_pid[30:15],
  // grant_mode[38:31], zero pad[39].
  output logic [prs_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser fields from bit 0: granted.
  output logic                            m_tuser,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [prs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [prs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import prs_pkg::*;

  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  ctrl_word_t  cw;
  cond_flags_t flags;

  // Configuration register.
  logic [ENTRY_COUNT_W-1:0] entry_count;

  // Latched input word.
  logic                    act_q;
  logic [SLOT_FIELD_W-1:0] slot_q;
  entry_t                  entry_q;
  logic [TIME_W-1:0]       now_q;

  // Scan state.
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] ptr_work;
  logic [SLOT_W-1:0] k;
  logic [SLOT_W-1:0] scan_i;
  logic [SLOT_W-1:0] rr_pointer;

  // Request tables.
  entry_t            data_mem [MAX_ENTRIES];
  logic [TIME_W-1:0] stamp_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] stamp_valid;
  entry_t            rd_data;
  logic [TIME_W-1:0] rd_stamp;
  logic              rd_stamp_ok;

  // Output register.
  logic                    granted_q;
  logic [SLOT_FIELD_W-1:0] out_slot;
  logic [ID_W-1:0]         out_id;
  logic [PID_W-1:0]        out_pid;
  logic [MODE_W-1:0]       out_mode;

  // Derived control signals.
  logic              in_accept;
  logic              out_busy;
  logic              out_load;
  logic              ptr_ge;
  logic              slot_ok;
  logic [SLOT_W-1:0] ld_idx;
  logic [SLOT_W-1:0] k_next;
  logic [SLOT_W-1:0] rd_addr;
  logic [TIME_W-1:0] stamp_eff;
  logic [TIME_W-1:0] elapsed;
  logic              cfg_write;

  prs_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  assign s_tready  = cw.ready;
  assign in_accept = s_tvalid & s_tready;
  assign out_busy  = m_tvalid & ~m_tready;
  assign out_load  = ((cw.op == OP_GRANT) || (cw.op == OP_MISS)) && !out_busy;

  // Next slot in round-robin order among the active slots.
  assign k_next = (CNT_W'(k) == count - CNT_W'(1)) ? '0 : k + SLOT_W'(1);
  assign ptr_ge = (CNT_W'(ptr_work) >= count);
  assign slot_ok = (32'(slot_q) < 32'(MAX_ENTRIES));
  assign ld_idx  = SLOT_W'(slot_q);

  // Due test on the registered table read: elapsed time wraps modulo 2^16.
  assign stamp_eff = rd_stamp_ok ? rd_stamp : '0;
  assign elapsed   = now_q - stamp_eff;

  always_comb begin
    flags.in_valid   = s_tvalid;
    flags.is_load    = ~act_q;
    flags.count_zero = (count == '0);
    flags.ptr_ge     = ptr_ge;
    flags.due        = (elapsed >= rd_data.interval);
    flags.last       = (CNT_W'(scan_i) == count - CNT_W'(1));
    flags.out_busy   = out_busy;
  end

  // Table read address follows the slot about to be examined.
  always_comb begin
    unique case (cw.op)
      OP_START:   rd_addr = ptr_work;
      OP_ADVANCE: rd_addr = k_next;
      default:    rd_addr = k;
    endcase
  end

  // Configuration register write and read-back.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ENTRY_COUNT_W'(1);
    end else if (cfg_write && (paddr[2:2] == REG_ENTRY_COUNT)) begin
      entry_count <= pwdata[ENTRY_COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2:2] == REG_ENTRY_COUNT) ?
                  APB_DATA_W'(entry_count) : '0;

  // Capture the accepted input word.
  always_ff @(posedge clk) begin
    if (cw.op == OP_LATCH && in_accept) begin
      act_q           <= s_tuser;
      slot_q          <= s_tdata[3:0];
      entry_q.can_id  <= s_tdata[14:4];
      entry_q.pid     <= s_tdata[30:15];
      entry_q.mode    <= s_tdata[38:31];
      entry_q.interval <= s_tdata[54:39];
      now_q           <= s_tdata[70:55];
    end
  end

  // Scan registers: saturated count, pointer fold, slot and step counters.
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_SETUP: begin
        if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
          count <= CNT_W'(MAX_ENTRIES);
        end else begin
          count <= CNT_W'(entry_count);
        end
        ptr_work <= rr_pointer;
      end
      OP_REDUCE: begin
        if (ptr_ge) begin
          ptr_work <= SLOT_W'(CNT_W'(ptr_work) - count);
        end
      end
      OP_START: begin
        k      <= ptr_work;
        scan_i <= '0;
      end
      OP_ADVANCE: begin
        k      <= k_next;
        scan_i <= scan_i + SLOT_W'(1);
      end
      default: ;
    endcase
  end

  // Round-robin pointer moves past each granted slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      rr_pointer <= '0;
    end else if (cw.op == OP_GRANT && out_load) begin
      rr_pointer <= k_next;
    end
  end

  // Request field memory: written by loads, read during the scan.
  always_ff @(posedge clk) begin
    if (cw.op == OP_LOAD && slot_ok) begin
      data_mem[ld_idx] <= entry_q;
    end
    rd_data <= data_mem[rd_addr];
  end

  // Issue stamp memory: written on a grant, read during the scan.
  always_ff @(posedge clk) begin
    if (cw.op == OP_GRANT && out_load) begin
      stamp_mem[k] <= now_q;
    end
    rd_stamp    <= stamp_mem[rd_addr];
    rd_stamp_ok <= stamp_valid[rd_addr];
  end

  // Stamp valid bits: a cleared bit reads as a zero stamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_valid <= '0;
    end else if (cw.op == OP_LOAD && slot_ok) begin
      stamp_valid[ld_idx] <= 1'b0;
    end else if (cw.op == OP_GRANT && out_load) begin
      stamp_valid[k] <= 1'b1;
    end
  end

  // Output register: filled on a grant or a miss, emptied when the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cw.op == OP_GRANT) begin
        granted_q <= 1'b1;
        out_slot  <= SLOT_FIELD_W'(k);
        out_id    <= rd_data.can_id;
        out_pid   <= rd_data.pid;
        out_mode  <= rd_data.mode;
      end else begin
        granted_q <= 1'b0;
        out_slot  <= '0;
        out_id    <= '0;
        out_pid   <= '0;
        out_mode  <= '0;
      end
    end
  end

  assign m_tuser = granted_q;
  assign m_tdata = {1'b0, out_mode, out_pid, out_id, out_slot};

endmodule

[hdl/prs_useq.sv]
// Microcode sequencer of the periodic request scheduler.
// Holds the step counter and the control program; branches on datapath flags.
// Depends on prs_pkg.
module prs_useq (
  input  logic                  clk,
  input  logic                  rst,
  input  prs_pkg::cond_flags_t  flags,
  output prs_pkg::ctrl_word_t   cw
);
  import prs_pkg::*;

  // Program step addresses.
  localparam step_t STEP_WAIT   = 4'd0;
  localparam step_t STEP_DECODE = 4'd1;
  localparam step_t STEP_ZERO   = 4'd2;
  localparam step_t STEP_REDUCE = 4'd3;
  localparam step_t STEP_START  = 4'd4;
  localparam step_t STEP_EVAL   = 4'd5;
  localparam step_t STEP_NEXT   = 4'd6;
  localparam step_t STEP_HIT    = 4'd7;
  localparam step_t STEP_MISS   = 4'd8;
  localparam step_t STEP_LOAD   = 4'd9;

  // Control program: one word per step.
  function automatic ctrl_word_t rom_word(input step_t s);
    ctrl_word_t w;
    w = '{ready: 1'b0, op: OP_NONE, cond: COND_ALWAYS,
          t_true: STEP_WAIT, t_false: STEP_WAIT};
    unique case (s)
      STEP_WAIT:   w = '{ready: 1'b1, op: OP_LATCH, cond: COND_IN_VALID,
                         t_true: STEP_DECODE, t_false: STEP_WAIT};
      STEP_DECODE: w = '{ready: 1'b0, op: OP_SETUP, cond: COND_IS_LOAD,
                         t_true: STEP_LOAD, t_false: STEP_ZERO};
      STEP_ZERO:   w = '{ready: 1'b0, op: OP_NONE, cond: COND_COUNT_ZERO,
                         t_true: STEP_MISS, t_false: STEP_REDUCE};
      STEP_REDUCE: w = '{ready: 1'b0, op: OP_REDUCE, cond: COND_PTR_GE,
                         t_true: STEP_REDUCE, t_false: STEP_START};
      STEP_START:  w = '{ready: 1'b0, op: OP_START, cond: COND_ALWAYS,
                         t_true: STEP_EVAL, t_false: STEP_EVAL};
      STEP_EVAL:   w = '{ready: 1'b0, op: OP_NONE, cond: COND_DUE,
                         t_true: STEP_HIT, t_false: STEP_NEXT};
      STEP_NEXT:   w = '{ready: 1'b0, op: OP_ADVANCE, cond: COND_LAST,
                         t_true: STEP_MISS, t_false: STEP_EVAL};
      STEP_HIT:    w = '{ready: 1'b0, op: OP_GRANT, cond: COND_OUT_BUSY,
                         t_true: STEP_HIT, t_false: STEP_WAIT};
      STEP_MISS:   w = '{ready: 1'b0, op: OP_MISS, cond: COND_OUT_BUSY,
                         t_true: STEP_MISS, t_false: STEP_WAIT};
      STEP_LOAD:   w = '{ready: 1'b0, op: OP_LOAD, cond: COND_ALWAYS,
                         t_true: STEP_WAIT, t_false: STEP_WAIT};
      default:     w = '{ready: 1'b0, op: OP_NONE, cond: COND_ALWAYS,
                         t_true: STEP_WAIT, t_false: STEP_WAIT};
    endcase
    return w;
  endfunction

  step_t pc;
  step_t pc_next;
  logic  cond_true;

  assign cw = rom_word(pc);

  // Evaluate the branch condition of the current word.
  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:     cond_true = 1'b1;
      COND_IN_VALID:   cond_true = flags.in_valid;
      COND_IS_LOAD:    cond_true = flags.is_load;
      COND_COUNT_ZERO: cond_true = flags.count_zero;
      COND_PTR_GE:     cond_true = flags.ptr_ge;
      COND_DUE:        cond_true = flags.due;
      COND_LAST:       cond_true = flags.last;
      COND_OUT_BUSY:   cond_true = flags.out_busy;
    endcase
    pc_next = cond_true ? cw.t_true : cw.t_false;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[tb/tb_periodic_request_scheduler_core.sv]
// Self-checking testbench for periodic_request_scheduler_core: slot loads, round-robin grants,
// entry_count settings and readback, with random input gaps and output back-pressure.
// Depends on prs_pkg and periodic_request_scheduler_core.
module tb_periodic_request_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import prs_pkg::*;

  // Input word kinds carried on s_tuser.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam logic [APB_ADDR_W-1:0] ADDR_ENTRY_COUNT = APB_ADDR_W'(4 * REG_ENTRY_COUNT);

  // Bit positions of the fields inside m_tdata.
  localparam int GID_LSB   = SLOT_FIELD_W;
  localparam int GPID_LSB  = GID_LSB + ID_W;
  localparam int GMODE_LSB = GPID_LSB + PID_W;

  localparam int SETTLE_CYCLES  = 8;
  localparam int FINAL_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TABLE_DEPTH    = PRS_MAX_ENTRIES;

  // One output word as predicted.
  typedef struct packed {
    logic                    granted;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ID_W-1:0]         can_id;
    logic [PID_W-1:0]        pid;
    logic [MODE_W-1:0]       mode;
  } grant_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // s_tdata fields from bit 0: slot, entry_id, entry_pid, entry_mode, entry_interval, now_ms.
  logic [S_TDATA_W-1:0]  s_tdata;
  // s_tuser fields from bit 0: action.
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // m_tdata fields from bit 0: grant_slot, grant_id, grant_pid, grant_mode.
  logic [M_TDATA_W-1:0]  m_tdata;
  // m_tuser fields from bit 0: granted.
  logic                  m_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copy of the request table and scheduler state.
  logic [ID_W-1:0]          sched_id    [TABLE_DEPTH];
  logic [PID_W-1:0]         sched_pid   [TABLE_DEPTH];
  logic [MODE_W-1:0]        sched_mode  [TABLE_DEPTH];
  logic [IVAL_W-1:0]        sched_ival  [TABLE_DEPTH];
  logic [TIME_W-1:0]        sched_stamp [TABLE_DEPTH];
  int                       rr_next;
  logic [ENTRY_COUNT_W-1:0] active_setting;

  grant_t            grant_queue[$];
  int                errors;
  int                idle_cycles;
  int                burst_left;
  logic              gaps_on;
  logic [TIME_W-1:0] clock_ms;

  periodic_request_scheduler_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic logic [S_TDATA_W-1:0] pack_word(
    input logic [SLOT_FIELD_W-1:0] slot, input logic [ID_W-1:0] can_id,
    input logic [PID_W-1:0] pid, input logic [MODE_W-1:0] mode,
    input logic [IVAL_W-1:0] ival, input logic [TIME_W-1:0] now);
    return S_TDATA_W'({now, ival, mode, pid, can_id, slot});
  endfunction

  // Round-robin scan over the active slots; a grant restamps the slot and moves the pointer.
  function automatic grant_t next_grant(input logic [TIME_W-1:0] now);
    grant_t            g;
    int                active;
    int                first;
    int                k;
    logic [TIME_W-1:0] elapsed;
    g = '0;
    active = (active_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_setting);
    if (active == 0) begin
      return g;
    end
    first = rr_next % active;
    for (int i = 0; i < active; i++) begin
      k = (first + i) % active;
      elapsed = now - sched_stamp[k];
      if (elapsed >= sched_ival[k]) begin
        sched_stamp[k] = now;
        rr_next = (k + 1) % active;
        g.granted = 1'b1;
        g.slot = SLOT_FIELD_W'(k);
        g.can_id = sched_id[k];
        g.pid = sched_pid[k];
        g.mode = sched_mode[k];
        return g;
      end
    end
    return g;
  endfunction

  // Sends one word in bursts with random gaps; valid stays high after acceptance so
  // back-to-back words need no drop in between.
  task automatic send_word(input logic act, input logic [S_TDATA_W-1:0] data);
    int                      gap;
    logic [SLOT_FIELD_W-1:0] slot;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // Update the shadow state in acceptance order.
    if (act == ACT_LOAD) begin
      slot = data[SLOT_FIELD_W-1:0];
      {sched_ival[slot], sched_mode[slot], sched_pid[slot], sched_id[slot]} =
        data[SLOT_FIELD_W +: ID_W + PID_W + MODE_W + IVAL_W];
      sched_stamp[slot] = '0;
    end else begin
      grant_queue.push_back(next_grant(data[S_TDATA_W-2 -: TIME_W]));
    end
  endtask

  task automatic load_slot(input logic [SLOT_FIELD_W-1:0] slot, input logic [ID_W-1:0] can_id,
                           input logic [PID_W-1:0] pid, input logic [MODE_W-1:0] mode,
                           input logic [IVAL_W-1:0] ival);
    send_word(ACT_LOAD, pack_word(slot, can_id, pid, mode, ival, TIME_W'($urandom)));
  endtask

  // Request word; the load fields carry noise that the block must ignore.
  task automatic request_at(input logic [TIME_W-1:0] now);
    send_word(ACT_REQUEST, pack_word(SLOT_FIELD_W'($urandom), ID_W'($urandom), PID_W'($urandom),
                                     MODE_W'($urandom), IVAL_W'($urandom), now));
  endtask

  // Lets every expected word arrive and any load finish before touching the registers.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_ENTRY_COUNT;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_entry_count();
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[ENTRY_COUNT_W-1:0] !== active_setting) begin
      report_error($sformatf("entry_count read %0d, expected %0d",
                             rdata[ENTRY_COUNT_W-1:0], active_setting));
    end
  endtask

  task automatic set_entry_count(input logic [ENTRY_COUNT_W-1:0] value);
    logic [APB_DATA_W-1:0] unused;
    wait_idle();
    apb_access(1'b1, APB_DATA_W'(value), unused);
    active_setting = value;
    check_entry_count();
  endtask

  // Reset value of the register.
  task automatic test_reset_value();
    check_entry_count();
  endtask

  // Fill every slot; slot 0 and slot 15 take the extremes of each field.
  task automatic test_table_load();
    load_slot(0, '0, '0, '0, '1);
    for (int s = 1; s < TABLE_DEPTH - 1; s++) begin
      load_slot(SLOT_FIELD_W'(s), ID_W'($urandom), PID_W'($urandom), MODE_W'($urandom), 200);
    end
    load_slot(SLOT_FIELD_W'(TABLE_DEPTH - 1), '1, '1, '1, '0);
  endtask

  // One active slot with the longest interval: a miss, then a grant at the wrap point.
  task automatic test_single_slot();
    request_at(16'h0000);
    request_at(16'hFFFF);
    clock_ms = 16'hFFFF;
  endtask

  // No active slot: the request reports nothing due.
  task automatic test_zero_count();
    set_entry_count(0);
    clock_ms = 16'h0100;
    request_at(clock_ms);
  endtask

  // A count above the table depth saturates; the scan walks past the slot not yet due.
  task automatic test_saturated_count();
    set_entry_count('1);
    repeat (4) request_at(clock_ms);
  endtask

  // Lowering the count below the pointer folds the scan start back into range.
  task automatic test_pointer_fold();
    set_entry_count(3);
    clock_ms = clock_ms + TIME_W'(300);
    repeat (2) request_at(clock_ms);
  endtask

  // Random loads and requests with time moving mostly in small steps, sometimes wrapping.
  task automatic test_random_traffic(input logic [ENTRY_COUNT_W-1:0] count, input int words,
                                     input logic with_gaps);
    logic [IVAL_W-1:0]       ival;
    logic [SLOT_FIELD_W-1:0] slot;
    set_entry_count(count);
    gaps_on = with_gaps;
    for (int n = 0; n < words; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 9))
          0:       ival = '0;
          1:       ival = '1;
          2:       ival = IVAL_W'($urandom);
          default: ival = IVAL_W'($urandom_range(0, 60));
        endcase
        slot = $urandom_range(0, 1) ? SLOT_FIELD_W'($urandom) : SLOT_FIELD_W'($urandom_range(0, 3));
        load_slot(slot, ID_W'($urandom), PID_W'($urandom), MODE_W'($urandom), ival);
      end else begin
        case ($urandom_range(0, 9))
          0:       clock_ms = clock_ms + TIME_W'($urandom);
          1, 2:    clock_ms = clock_ms + TIME_W'($urandom_range(16, 300));
          default: clock_ms = clock_ms + TIME_W'($urandom_range(0, 15));
        endcase
        request_at(clock_ms);
      end
    end
    gaps_on = 1'b1;
  endtask

  // Compare each output word with the oldest prediction.
  always @(posedge clk) begin : check_grants
    grant_t exp_g;
    if (!rst && m_tvalid && m_tready) begin
      if (grant_queue.size() == 0) begin
        report_error($sformatf("unexpected word tuser=%0b tdata=%h", m_tuser, m_tdata));
      end else begin
        exp_g = grant_queue.pop_front();
        if (m_tuser !== exp_g.granted) begin
          report_error($sformatf("granted %0b, expected %0b", m_tuser, exp_g.granted));
        end
        if (m_tdata[SLOT_FIELD_W-1:0] !== exp_g.slot) begin
          report_error($sformatf("grant_slot %0d, expected %0d",
                                 m_tdata[SLOT_FIELD_W-1:0], exp_g.slot));
        end
        if (m_tdata[GID_LSB +: ID_W] !== exp_g.can_id) begin
          report_error($sformatf("grant_id %h, expected %h", m_tdata[GID_LSB +: ID_W],
                                 exp_g.can_id));
        end
        if (m_tdata[GPID_LSB +: PID_W] !== exp_g.pid) begin
          report_error($sformatf("grant_pid %h, expected %h", m_tdata[GPID_LSB +: PID_W],
                                 exp_g.pid));
        end
        if (m_tdata[GMODE_LSB +: MODE_W] !== exp_g.mode) begin
          report_error($sformatf("grant_mode %h, expected %h", m_tdata[GMODE_LSB +: MODE_W],
                                 exp_g.mode));
        end
      end
    end
  end

  // Receiver back-pressure: runs of full readiness, random stalls and long stalls.
  initial begin : drive_ready
    int run;
    int pick;
    m_tready = 1'b0;
    forever begin
      pick = $urandom_range(0, 3);
      run = (pick == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
      repeat (run) begin
        @(negedge clk);
        case (pick)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= 1'b0;
        endcase
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_tests
    logic [ENTRY_COUNT_W-1:0] phase_count [10];
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = ACT_LOAD;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    errors      = 0;
    idle_cycles = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    clock_ms    = '0;
    rr_next     = 0;
    active_setting = 1;
    phase_count = '{16, 1, 31, 0, 5, 24, 2, 9, 16, 3};
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      sched_id[s]    = '0;
      sched_pid[s]   = '0;
      sched_mode[s]  = '0;
      sched_ival[s]  = '0;
      sched_stamp[s] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_value();
    test_table_load();
    test_single_slot();
    test_zero_count();
    test_saturated_count();
    test_pointer_fold();
    for (int p = 0; p < 10; p++) begin
      test_random_traffic(phase_count[p], 135, (p % 4) != 2);
    end

    wait_idle();
    repeat (FINAL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[periodic_request_scheduler_core.f]
hdl/prs_pkg.sv
hdl/prs_useq.sv
hdl/periodic_request_scheduler_core.sv
tb/tb_periodic_request_scheduler_core.sv
